// ===== design/tcs_pkg.sv =====
// ---------------------------------------------------------------------------
// tcs_pkg: shared types, wheel tables and mod-26 helpers
// Holds the rotor wirings, their inverses, register indexes and the
// small arithmetic functions used by the letter path and the stepper.
// ---------------------------------------------------------------------------
package tcs_pkg;

  localparam int LETTERS = 26;
  localparam int LW      = 5;

  typedef logic [LW-1:0] letter_t;
  typedef letter_t wheel_t [LETTERS];

  // Configuration register indexes.
  localparam int CFG_IW = 3;
  typedef logic [CFG_IW-1:0] cfg_index_t;
  localparam cfg_index_t REG_TURNOVER_FAST   = 3'd0;
  localparam cfg_index_t REG_TURNOVER_MIDDLE = 3'd1;
  localparam cfg_index_t REG_START_FAST      = 3'd2;
  localparam cfg_index_t REG_START_MIDDLE    = 3'd3;
  localparam cfg_index_t REG_START_SLOW      = 3'd4;

  localparam letter_t TURNOVER_FAST_RST   = 5'd24;
  localparam letter_t TURNOVER_MIDDLE_RST = 5'd4;
  localparam letter_t START_RST           = 5'd0;

  typedef struct packed {
    letter_t turnover_fast;
    letter_t turnover_middle;
    letter_t start_fast;
    letter_t start_middle;
    letter_t start_slow;
  } cfg_t;

  typedef struct packed {
    letter_t fast;
    letter_t middle;
    letter_t slow;
  } pos_t;

  typedef struct packed {
    letter_t cipher_letter;
    letter_t pos_fast_out;
    letter_t pos_middle_out;
    letter_t pos_slow_out;
  } result_t;

  localparam wheel_t WHEEL_FAST = '{
    5'd11, 5'd15, 5'd6,  5'd18, 5'd25, 5'd12, 5'd7,  5'd0,  5'd4,  5'd14, 5'd16, 5'd10, 5'd21,
    5'd23, 5'd17, 5'd5,  5'd24, 5'd1,  5'd20, 5'd19, 5'd13, 5'd8,  5'd2,  5'd9,  5'd3,  5'd22};
  localparam wheel_t WHEEL_MIDDLE = '{
    5'd18, 5'd11, 5'd21, 5'd6,  5'd1,  5'd19, 5'd5,  5'd23, 5'd9,  5'd16, 5'd14, 5'd7,  5'd4,
    5'd22, 5'd8,  5'd17, 5'd25, 5'd24, 5'd0,  5'd12, 5'd10, 5'd15, 5'd2,  5'd13, 5'd3,  5'd20};
  localparam wheel_t WHEEL_SLOW = '{
    5'd2,  5'd9,  5'd6,  5'd3,  5'd15, 5'd18, 5'd7,  5'd10, 5'd19, 5'd20, 5'd17, 5'd0,  5'd22,
    5'd25, 5'd23, 5'd5,  5'd12, 5'd24, 5'd13, 5'd16, 5'd14, 5'd1,  5'd21, 5'd11, 5'd8,  5'd4};
  localparam wheel_t WHEEL_REFLECT = '{
    5'd8,  5'd12, 5'd4,  5'd19, 5'd2,  5'd6,  5'd5,  5'd17, 5'd0,  5'd24, 5'd18, 5'd16, 5'd1,
    5'd25, 5'd23, 5'd22, 5'd11, 5'd7,  5'd10, 5'd3,  5'd21, 5'd20, 5'd15, 5'd14, 5'd9,  5'd13};
  localparam wheel_t WHEEL_ENTRY = '{
    5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd25, 5'd20, 5'd8,  5'd14, 5'd0,  5'd18, 5'd3,  5'd5,
    5'd6,  5'd7,  5'd9,  5'd10, 5'd15, 5'd24, 5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12, 5'd11};

  // Builds the inverse wiring of a wheel at elaboration time.
  function automatic wheel_t invert(wheel_t w);
    wheel_t inv;
    for (int i = 0; i < LETTERS; i++) begin
      inv[i] = '0;
    end
    for (int i = 0; i < LETTERS; i++) begin
      inv[w[i]] = LW'(i);
    end
    return inv;
  endfunction

  localparam wheel_t WHEEL_FAST_INV   = invert(WHEEL_FAST);
  localparam wheel_t WHEEL_MIDDLE_INV = invert(WHEEL_MIDDLE);
  localparam wheel_t WHEEL_SLOW_INV   = invert(WHEEL_SLOW);
  localparam wheel_t WHEEL_ENTRY_INV  = invert(WHEEL_ENTRY);

  // Folds a 5-bit value into 0..25.
  function automatic letter_t fold26(letter_t v);
    return (v >= LW'(LETTERS)) ? LW'(v - LW'(LETTERS)) : v;
  endfunction

  // (a + b) mod 26 for a, b below 26.
  function automatic letter_t add26(letter_t a, letter_t b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= (LW+1)'(LETTERS)) ? LW'(s - (LW+1)'(LETTERS)) : s[LW-1:0];
  endfunction

  // (a - b) mod 26 for a, b below 26.
  function automatic letter_t sub26(letter_t a, letter_t b);
    logic [LW:0] s;
    s = {1'b0, a} + (LW+1)'(LETTERS) - {1'b0, b};
    return (s >= (LW+1)'(LETTERS)) ? LW'(s - (LW+1)'(LETTERS)) : s[LW-1:0];
  endfunction

  // Next rotor position, wrapping from Z back to A.
  function automatic letter_t advance(letter_t p);
    return (p >= LW'(LETTERS - 1)) ? '0 : LW'(p + 1'b1);
  endfunction

endpackage

// ===== design/three_rotor_cipher_stepper_top.sv =====
// ---------------------------------------------------------------------------
// three_rotor_cipher_stepper_top: three-rotor cipher with rotor stepping
// Top level: configuration registers, input and result registers around
// the letter path and the rotor stepper.
// ---------------------------------------------------------------------------
// Usage:
// Each input word on the s_ channel is either a key press (s_tuser = 0,
// letter in s_tdata) or a rotor reset action (s_tuser = 1). A key press is
// enciphered with the current rotor positions and then the rotors step; a
// reset action loads the start positions and returns letter zero. Every
// input word yields exactly one result word on the m_ channel carrying the
// cipher letter and the rotor positions after the word.
// The configuration channel writes the turnover and start registers; it is
// always ready, and writes are expected only while the block is idle.
// m_tvalid rises once an accepted word has passed the input register and then
// the letter path and stepper into the result register; while the receiver
// stalls, the word can wait in the input register. Throughput is one word
// per cycle while the receiver takes every result word, set by the single
// pass of table lookups and mod-26 adds between those registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; s_tready falls only when both are full.
// Reset (rst, synchronous) empties both registers, sets all positions to A,
// clears the double-step flag and loads the register defaults.
// ---------------------------------------------------------------------------
module three_rotor_cipher_stepper_top (
  input  logic       clk,
  input  logic       rst,
  // Input words.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] key_letter, [7:5] zero
  input  logic       s_tuser,   // [0] action (1 = reset rotor positions)
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [4:0] cipher_letter, [9:5] pos_fast_out,
                                // [14:10] pos_middle_out, [19:15] pos_slow_out,
                                // [23:20] zero
  // Configuration writes.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  tcs_pkg::cfg_index_t     cfg_index,
  input  tcs_pkg::letter_t        cfg_data
);
  import tcs_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    in_action;
  letter_t in_key;
  logic    out_valid;
  result_t out_data;
  logic    advance_out;
  logic    fire;
  pos_t    pos;
  pos_t    pos_next;
  letter_t path_letter;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turnover_fast   <= TURNOVER_FAST_RST;
      cfg.turnover_middle <= TURNOVER_MIDDLE_RST;
      cfg.start_fast      <= START_RST;
      cfg.start_middle    <= START_RST;
      cfg.start_slow      <= START_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TURNOVER_FAST:   cfg.turnover_fast   <= cfg_data;
        REG_TURNOVER_MIDDLE: cfg.turnover_middle <= cfg_data;
        REG_START_FAST:      cfg.start_fast      <= cfg_data;
        REG_START_MIDDLE:    cfg.start_middle    <= cfg_data;
        REG_START_SLOW:      cfg.start_slow      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register can take a new word when it is empty or draining.
  assign advance_out = !out_valid || m_tready;
  assign fire        = in_valid && advance_out;
  assign s_tready    = !in_valid || advance_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_key    <= s_tdata[LW-1:0];
    end
  end

  tcs_path u_path (
    .key_letter    (in_key),
    .pos           (pos),
    .cipher_letter (path_letter)
  );

  tcs_rotor u_rotor (
    .clk      (clk),
    .rst      (rst),
    .step_en  (fire),
    .action   (in_action),
    .cfg      (cfg),
    .pos      (pos),
    .pos_next (pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.cipher_letter  <= in_action ? '0 : path_letter;
      out_data.pos_fast_out   <= pos_next.fast;
      out_data.pos_middle_out <= pos_next.middle;
      out_data.pos_slow_out   <= pos_next.slow;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_data.pos_slow_out, out_data.pos_middle_out,
                     out_data.pos_fast_out, out_data.cipher_letter};

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled with room in the pipeline");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed word did not reach the result register");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cipher_letter < LW'(LETTERS))
    else $error("cipher letter out of range");
`endif

endmodule

// ===== design/tcs_path.sv =====
// ---------------------------------------------------------------------------
// tcs_path: letter substitution path
// Entry wheel, three rotors forward, reflector, three rotors back and the
// entry wheel again, all for the current rotor positions.
// ---------------------------------------------------------------------------
module tcs_path (
  input  tcs_pkg::letter_t key_letter,
  input  tcs_pkg::pos_t    pos,
  output tcs_pkg::letter_t cipher_letter
);
  import tcs_pkg::*;

  letter_t x_entry;
  letter_t x_fast;
  letter_t x_middle;
  letter_t x_slow;
  letter_t x_reflect;
  letter_t y_slow;
  letter_t y_middle;
  letter_t y_fast;

  always_comb begin
    x_entry   = WHEEL_ENTRY_INV[fold26(key_letter)];
    x_fast    = WHEEL_FAST[add26(x_entry, pos.fast)];
    x_middle  = WHEEL_MIDDLE[add26(x_fast, pos.middle)];
    x_slow    = WHEEL_SLOW[add26(x_middle, pos.slow)];
    x_reflect = WHEEL_REFLECT[x_slow];
    y_slow    = sub26(WHEEL_SLOW_INV[x_reflect], pos.slow);
    y_middle  = sub26(WHEEL_MIDDLE_INV[y_slow], pos.middle);
    y_fast    = sub26(WHEEL_FAST_INV[y_middle], pos.fast);
    cipher_letter = WHEEL_ENTRY[y_fast];
  end

endmodule

// ===== design/tcs_rotor.sv =====
// ---------------------------------------------------------------------------
// tcs_rotor: rotor position state and stepping
// Holds the three positions and the armed double-step flag, and works out
// the positions that follow the word now being processed.
// ---------------------------------------------------------------------------
module tcs_rotor (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  logic          action,
  input  tcs_pkg::cfg_t cfg,
  output tcs_pkg::pos_t pos,
  output tcs_pkg::pos_t pos_next
);
  import tcs_pkg::*;

  logic    pending;
  logic    pending_next;
  letter_t mid_tmp;

  always_comb begin
    mid_tmp      = pos.middle;
    pos_next     = pos;
    pending_next = pending;
    if (action) begin
      pos_next.fast   = fold26(cfg.start_fast);
      pos_next.middle = fold26(cfg.start_middle);
      pos_next.slow   = fold26(cfg.start_slow);
    end else begin
      if (pos.fast == cfg.turnover_fast) begin
        mid_tmp = advance(pos.middle);
      end
      pos_next.fast = advance(pos.fast);
      if (pending) begin
        mid_tmp       = advance(mid_tmp);
        pos_next.slow = advance(pos.slow);
      end
      pos_next.middle = mid_tmp;
      pending_next    = (mid_tmp == cfg.turnover_middle);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= 1'b0;
    end else if (step_en) begin
      pos     <= pos_next;
      pending <= pending_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos.fast < LW'(LETTERS) && pos.middle < LW'(LETTERS) && pos.slow < LW'(LETTERS))
    else $error("rotor position left the alphabet");

  a_fast_steps: assert property (@(posedge clk) disable iff (rst)
    step_en && !action |=> pos.fast == advance($past(pos.fast)))
    else $error("fast rotor did not step on a key press");

  a_reset_keeps_flag: assert property (@(posedge clk) disable iff (rst)
    step_en && action |=> pending == $past(pending))
    else $error("reset action changed the double-step flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> pos == $past(pos))
    else $error("rotor positions moved without a word");
`endif

endmodule
